// ----- hdl/lsp_pkg.sv -----
// shared constants, types and width helpers for the line sensor position unit
package lsp_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 10;

  localparam int THR_W       = 10;
  localparam int VALUE_W     = 10;
  localparam int WACC_W      = 15;
  localparam int VACC_W      = 13;
  localparam int SCALE_TOP   = 1000;
  localparam int SCALE_SHIFT = 10;
  localparam int INVERT_TOP  = 1023;
  localparam int EDGE_STEP   = 500;
  localparam int QUEUE_DEPTH = 2;

  localparam int LINE_THR_RST = 500;
  localparam int INCL_THR_RST = 100;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_THR   = 2'd0,
    REG_INCL_THR   = 2'd1,
    REG_WHITE_LINE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int edge_pos(input int n);
    return (n - 1) * EDGE_STEP;
  endfunction

  function automatic int pos_width(input int n);
    return $clog2(edge_pos(n) + 1) + 1;
  endfunction

  function automatic int quot_width(input int n);
    return max_int(SCALE_SHIFT, $clog2(2 * edge_pos(n) + 1));
  endfunction

  function automatic int raw_width(input int sb);
    return sb + 1;
  endfunction

  function automatic int item_width(input int n, input int sb);
    return 1 + $clog2(n) + raw_width(sb);
  endfunction

endpackage

// ----- hdl/lsp_front.sv -----
// input stage: takes items, drops unknown channels, forms the ambient-corrected raw value
module lsp_front #(
  parameter int NUM_CHANNELS = lsp_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = lsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  input  logic                                                     in_push,
  output logic                                                     in_full,
  input  logic                                                     in_req_type,
  input  logic [$clog2(NUM_CHANNELS)-1:0]                          in_channel,
  input  logic [SAMPLE_BITS-1:0]                                   in_lit_sample,
  input  logic [SAMPLE_BITS-1:0]                                   in_dark_sample,
  input  logic                                                     q_full,
  output logic                                                     q_push,
  output logic [lsp_pkg::item_width(NUM_CHANNELS, SAMPLE_BITS)-1:0] q_data
);

  localparam int CH_W  = $clog2(NUM_CHANNELS);
  localparam int RAW_W = lsp_pkg::raw_width(SAMPLE_BITS);
  localparam int IT_W  = lsp_pkg::item_width(NUM_CHANNELS, SAMPLE_BITS);
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

  logic             valid_r, valid_nxt;
  logic [IT_W-1:0]  item_r, item_nxt;
  logic             accept;
  logic             keep;
  logic [RAW_W-1:0] raw;

  assign in_full = valid_r && q_full;
  assign q_push  = valid_r && !q_full;
  assign q_data  = item_r;
  assign accept  = in_push && !in_full;
  assign keep    = accept && ({1'b0, in_channel} < (CH_W + 1)'(NUM_CHANNELS));
  assign raw     = RAW_W'(in_lit_sample) + RAW_W'(SAMPLE_MAX) - RAW_W'(in_dark_sample);

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (keep) begin
      valid_nxt = 1'b1;
      item_nxt  = {in_req_type, in_channel, raw};
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ----- hdl/lsp_fifo.sv -----
// short queue between the input stage and the processing engine
module lsp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int DEPTH = lsp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/lsp_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle, saturates on overflow
module lsp_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 13,
  parameter int Q_W   = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output lsp_pkg::div_stat_t stat,
  output logic [Q_W-1:0]     quot
);

  localparam int CMP_W = lsp_pkg::max_int(NUM_W - Q_W, DEN_W);
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   sh_r, sh_nxt;
  logic [CMP_W-1:0] hi_part;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign hi_part = CMP_W'(num >> Q_W);
  assign trial   = {rem_r, sh_r[Q_W-1]};
  assign qbit    = (trial >= {1'b0, den_r});
  assign stat    = '{busy: busy_r, done: done_r};
  assign quot    = sh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    if (start) begin
      den_nxt = den;
      if (hi_part >= CMP_W'(den)) begin
        sh_nxt   = '1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = hi_part[DEN_W-1:0];
        sh_nxt   = num[Q_W-1:0];
        cnt_nxt  = CNT_W'(Q_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[Q_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
  end

endmodule

// ----- hdl/lsp_back.sv -----
// processing engine: calibration store, scaling, frame sums, position and result register
module lsp_back #(
  parameter int NUM_CHANNELS = lsp_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = lsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  input  logic                                                     cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]                            cfg_index,
  input  logic [lsp_pkg::CFG_DATA_W-1:0]                           cfg_wdata,
  input  logic                                                     q_empty,
  output logic                                                     q_pop,
  input  logic [lsp_pkg::item_width(NUM_CHANNELS, SAMPLE_BITS)-1:0] q_data,
  output logic                                                     out_valid,
  input  logic                                                     out_pop,
  output logic signed [lsp_pkg::pos_width(NUM_CHANNELS)-1:0]       out_position,
  output logic [NUM_CHANNELS-1:0]                                  out_mask
);

  localparam int CH_W    = $clog2(NUM_CHANNELS);
  localparam int RAW_W   = lsp_pkg::raw_width(SAMPLE_BITS);
  localparam int POS_W   = lsp_pkg::pos_width(NUM_CHANNELS);
  localparam int EDGE    = lsp_pkg::edge_pos(NUM_CHANNELS);
  localparam int Q_W     = lsp_pkg::quot_width(NUM_CHANNELS);
  localparam int VALUE_W = lsp_pkg::VALUE_W;
  localparam int THR_W   = lsp_pkg::THR_W;
  localparam int WACC_W  = lsp_pkg::WACC_W;
  localparam int VACC_W  = lsp_pkg::VACC_W;
  localparam int DEN_W   = lsp_pkg::max_int(VACC_W, RAW_W);
  localparam int NUM_W   = lsp_pkg::max_int(WACC_W, RAW_W) + lsp_pkg::SCALE_SHIFT;
  localparam int MIN_RST = 2 * ((1 << SAMPLE_BITS) - 1);

  localparam logic [CH_W-1:0]         LAST_CH  = CH_W'(NUM_CHANNELS - 1);
  localparam logic signed [POS_W-1:0] EDGE_P   = POS_W'(EDGE);
  localparam logic signed [POS_W-1:0] EDGE_NEG = POS_W'(-EDGE);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_SDIV  = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_FRAME = 7'b0010000,
    S_FDIV  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      req_r, req_nxt;
  logic [CH_W-1:0]           chan_r, chan_nxt;
  logic [RAW_W-1:0]          raw_r, raw_nxt;
  logic [VALUE_W-1:0]        val_r, val_nxt;
  logic [RAW_W-1:0]          min_r [NUM_CHANNELS];
  logic [RAW_W-1:0]          min_nxt [NUM_CHANNELS];
  logic [RAW_W-1:0]          max_r [NUM_CHANNELS];
  logic [RAW_W-1:0]          max_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]   mask_acc_r, mask_acc_nxt;
  logic [WACC_W-1:0]         wacc_r, wacc_nxt;
  logic [VACC_W-1:0]         vacc_r, vacc_nxt;
  logic signed [POS_W-1:0]   last_pos_r, last_pos_nxt;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [NUM_CHANNELS-1:0]   out_mask_r, out_mask_nxt;
  logic [THR_W-1:0]          line_thr_r, line_thr_nxt;
  logic [THR_W-1:0]          incl_thr_r, incl_thr_nxt;
  logic                      white_r, white_nxt;

  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  lsp_pkg::div_stat_t        div_stat;
  logic [Q_W-1:0]            div_quot;

  logic [RAW_W-1:0]          lo, hi;
  logic [VALUE_W-1:0]        scaled;
  logic [VALUE_W+CH_W-1:0]   wprod;
  logic                      out_load;

  assign lo       = min_r[chan_r];
  assign hi       = max_r[chan_r];
  assign scaled   = (div_quot > Q_W'(lsp_pkg::SCALE_TOP)) ?
                    VALUE_W'(lsp_pkg::SCALE_TOP) : div_quot[VALUE_W-1:0];
  assign wprod    = val_r * chan_r;
  assign out_load = (state_r == S_OUT) && !out_valid_r;

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_mask     = out_mask_r;

  lsp_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    chan_nxt      = chan_r;
    raw_nxt       = raw_r;
    val_nxt       = val_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    mask_acc_nxt  = mask_acc_r;
    wacc_nxt      = wacc_r;
    vacc_nxt      = vacc_r;
    last_pos_nxt  = last_pos_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_mask_nxt  = out_mask_r;
    line_thr_nxt  = line_thr_r;
    incl_thr_nxt  = incl_thr_r;
    white_nxt     = white_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;

    if (out_valid_r && out_pop) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop                       = 1'b1;
          {req_nxt, chan_nxt, raw_nxt} = q_data;
          state_nxt                   = S_PREP;
        end
      end
      S_PREP: begin
        if (!req_r) begin
          if (raw_r > hi) begin
            max_nxt[chan_r] = raw_r;
          end
          if (raw_r < lo) begin
            min_nxt[chan_r] = raw_r;
          end
          state_nxt = S_IDLE;
        end else if (hi <= lo || raw_r <= lo) begin
          val_nxt   = white_r ? VALUE_W'(lsp_pkg::INVERT_TOP) : '0;
          state_nxt = S_ACC;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(raw_r - lo) * NUM_W'(lsp_pkg::SCALE_TOP);
          div_den   = DEN_W'(hi - lo);
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_stat.done) begin
          val_nxt   = white_r ? VALUE_W'(lsp_pkg::INVERT_TOP) - scaled : scaled;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (val_r > line_thr_r) begin
          mask_acc_nxt[chan_r] = 1'b1;
        end
        if (val_r > incl_thr_r) begin
          wacc_nxt = wacc_r + WACC_W'(wprod);
          vacc_nxt = vacc_r + VACC_W'(val_r);
        end
        state_nxt = (chan_r == LAST_CH) ? S_FRAME : S_IDLE;
      end
      S_FRAME: begin
        state_nxt = S_OUT;
        if (mask_acc_r == '0) begin
          pos_nxt = last_pos_r[POS_W-1] ? EDGE_NEG : EDGE_P;
        end else if (mask_acc_r[0]) begin
          pos_nxt = EDGE_NEG;
        end else if (mask_acc_r[NUM_CHANNELS-1]) begin
          pos_nxt = EDGE_P;
        end else if (vacc_r == '0) begin
          pos_nxt = last_pos_r;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(wacc_r) * NUM_W'(lsp_pkg::SCALE_TOP);
          div_den   = DEN_W'(vacc_r);
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_stat.done) begin
          if (div_quot > Q_W'(2 * EDGE)) begin
            pos_nxt = EDGE_P;
          end else begin
            pos_nxt = $signed(POS_W'(div_quot)) - EDGE_P;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_mask_nxt  = mask_acc_r;
          last_pos_nxt  = pos_r;
          mask_acc_nxt  = '0;
          wacc_nxt      = '0;
          vacc_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (lsp_pkg::cfg_reg_t'(cfg_index))
        lsp_pkg::REG_LINE_THR:   line_thr_nxt = cfg_wdata[THR_W-1:0];
        lsp_pkg::REG_INCL_THR:   incl_thr_nxt = cfg_wdata[THR_W-1:0];
        lsp_pkg::REG_WHITE_LINE: white_nxt    = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_acc_r  <= '0;
      wacc_r      <= '0;
      vacc_r      <= '0;
      last_pos_r  <= '0;
      out_valid_r <= 1'b0;
      line_thr_r  <= THR_W'(lsp_pkg::LINE_THR_RST);
      incl_thr_r  <= THR_W'(lsp_pkg::INCL_THR_RST);
      white_r     <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        min_r[i] <= RAW_W'(MIN_RST);
        max_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      mask_acc_r  <= mask_acc_nxt;
      wacc_r      <= wacc_nxt;
      vacc_r      <= vacc_nxt;
      last_pos_r  <= last_pos_nxt;
      out_valid_r <= out_valid_nxt;
      line_thr_r  <= line_thr_nxt;
      incl_thr_r  <= incl_thr_nxt;
      white_r     <= white_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
    req_r      <= req_nxt;
    chan_r     <= chan_nxt;
    raw_r      <= raw_nxt;
    val_r      <= val_nxt;
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_mask_r <= out_mask_nxt;
  end

`ifndef ASSERT_OFF
  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_den != '0))
    else $error("divider started with zero divisor");

  a_div_only_measure: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> req_r)
    else $error("divider started for a calibration item");

  a_result_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (req_r && chan_r == LAST_CH))
    else $error("result loaded outside the last measurement channel");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (mask_acc_r == '0 && wacc_r == '0 && vacc_r == '0))
    else $error("frame sums not cleared after result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pos_r <= EDGE_P && out_pos_r >= EDGE_NEG))
    else $error("position out of range");
`endif

endmodule

// ----- hdl/line_sensor_position_unit.sv -----
// top level of the line sensor position unit
//
// One item carries one channel of the reflectance bar (lit and dark sample).
// Calibration items update that channel's min and max. Measurement items skip
// the divider when the channel span is not positive or raw is at or below
// min; otherwise the scaled value comes from the shared radix-2 divider (a
// 13-bit quotient for 8 channels, one bit per cycle), which returns an all-ones
// quotient when the scaled quotient overflows it. The last channel of a
// measurement frame adds a frame step, plus the weighted-average division
// when the line sits in the interior, and one result is then placed in the
// output register.
// The input stage and a 2-entry queue take items while the engine works; the
// engine waits only when a finished result has not yet been popped.
module line_sensor_position_unit #(
  parameter int NUM_CHANNELS = lsp_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = lsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_push,
  output logic                                               in_full,
  input  logic                                               in_req_type,
  input  logic [$clog2(NUM_CHANNELS)-1:0]                    in_channel,
  input  logic [SAMPLE_BITS-1:0]                             in_lit_sample,
  input  logic [SAMPLE_BITS-1:0]                             in_dark_sample,
  output logic                                               out_empty,
  input  logic                                               out_pop,
  output logic signed [lsp_pkg::pos_width(NUM_CHANNELS)-1:0] out_position,
  output logic [NUM_CHANNELS-1:0]                            out_on_line_mask,
  input  logic                                               cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]                      cfg_index,
  input  logic [lsp_pkg::CFG_DATA_W-1:0]                     cfg_wdata
);

  localparam int IT_W = lsp_pkg::item_width(NUM_CHANNELS, SAMPLE_BITS);

  logic            fq_push, fq_full, fq_pop, fq_empty;
  logic [IT_W-1:0] fq_wdata, fq_rdata;
  logic            res_valid;

  assign out_empty = !res_valid;

  lsp_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_channel     (in_channel),
    .in_lit_sample  (in_lit_sample),
    .in_dark_sample (in_dark_sample),
    .q_full         (fq_full),
    .q_push         (fq_push),
    .q_data         (fq_wdata)
  );

  lsp_fifo #(
    .WIDTH (IT_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .empty   (fq_empty)
  );

  lsp_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_empty      (fq_empty),
    .q_pop        (fq_pop),
    .q_data       (fq_rdata),
    .out_valid    (res_valid),
    .out_pop      (out_pop),
    .out_position (out_position),
    .out_mask     (out_on_line_mask)
  );

endmodule

// ----- tb/sv/tb_line_sensor_position_unit.sv -----
// testbench for the line sensor position unit: directed frames, random traffic, queue checks
module tb_line_sensor_position_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH           = lsp_pkg::NUM_CHANNELS_DEF;
  localparam int SB            = lsp_pkg::SAMPLE_BITS_DEF;
  localparam int CH_W          = $clog2(NCH);
  localparam int POS_W         = lsp_pkg::pos_width(NCH);
  localparam int SAMPLE_TOP    = (1 << SB) - 1;
  localparam int RAW_TOP       = 2 * SAMPLE_TOP;
  localparam int EDGE_LIMIT    = (NCH - 1) * lsp_pkg::EDGE_STEP;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;

  localparam logic REQ_CALIBRATE = 1'b0;
  localparam logic REQ_MEASURE   = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [NCH-1:0]          mask;
  } frame_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_push = 1'b0;
  logic                             in_full;
  logic                             in_req_type = 1'b0;
  logic [CH_W-1:0]                  in_channel = '0;
  logic [SB-1:0]                    in_lit_sample = '0;
  logic [SB-1:0]                    in_dark_sample = '0;
  logic                             out_empty;
  logic                             out_pop = 1'b0;
  logic signed [POS_W-1:0]          out_position;
  logic [NCH-1:0]                   out_on_line_mask;
  logic                             cfg_we = 1'b0;
  logic [lsp_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [lsp_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  // bar model state
  int             cal_lo [NCH];
  int             cal_hi [NCH];
  logic [NCH-1:0] mask_acc;
  int             weight_sum;
  int             value_sum;
  int             last_pos;
  int             line_thr;
  int             incl_thr;
  logic           white_line;

  frame_result_t expected_frames [$];
  int            mismatch_count = 0;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  logic          hold_start = 1'b0;
  int            hold_left = 0;
  int            stall_cycles = 0;

  line_sensor_position_unit #(
    .NUM_CHANNELS(NCH),
    .SAMPLE_BITS (SB)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_channel      (in_channel),
    .in_lit_sample   (in_lit_sample),
    .in_dark_sample  (in_dark_sample),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_position    (out_position),
    .out_on_line_mask(out_on_line_mask),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic init_bar_model();
    for (int i = 0; i < NCH; i++) begin
      cal_lo[i] = RAW_TOP;
      cal_hi[i] = 0;
    end
    mask_acc   = '0;
    weight_sum = 0;
    value_sum  = 0;
    last_pos   = 0;
    line_thr   = lsp_pkg::LINE_THR_RST;
    incl_thr   = lsp_pkg::INCL_THR_RST;
    white_line = 1'b0;
  endtask

  function automatic int scaled_value(input int ch, input int raw);
    int lo;
    int hi;
    int v;
    lo = cal_lo[ch];
    hi = cal_hi[ch];
    if (hi <= lo || raw <= lo) return 0;
    v = ((raw - lo) * lsp_pkg::SCALE_TOP) / (hi - lo);
    return (v > lsp_pkg::SCALE_TOP) ? lsp_pkg::SCALE_TOP : v;
  endfunction

  function automatic int frame_position();
    int p;
    if (mask_acc == '0) return (last_pos < 0) ? -EDGE_LIMIT : EDGE_LIMIT;
    if (mask_acc[0]) return -EDGE_LIMIT;
    if (mask_acc[NCH-1]) return EDGE_LIMIT;
    if (value_sum == 0) return last_pos;
    p = (weight_sum * lsp_pkg::SCALE_TOP) / value_sum - EDGE_LIMIT;
    if (p > EDGE_LIMIT) p = EDGE_LIMIT;
    if (p < -EDGE_LIMIT) p = -EDGE_LIMIT;
    return p;
  endfunction

  task automatic update_bar_model(input logic req, input logic [CH_W-1:0] ch,
                                  input logic [SB-1:0] lit, input logic [SB-1:0] dark);
    int            raw;
    int            value;
    frame_result_t res;
    raw = (int'(lit) + SAMPLE_TOP - int'(dark)) & 'h7FF;
    if (req == REQ_CALIBRATE) begin
      if (raw > cal_hi[ch]) cal_hi[ch] = raw;
      if (raw < cal_lo[ch]) cal_lo[ch] = raw;
    end else begin
      value = scaled_value(ch, raw);
      if (white_line) value = lsp_pkg::INVERT_TOP - value;
      if (value > line_thr) mask_acc[ch] = 1'b1;
      if (value > incl_thr) begin
        weight_sum = (weight_sum + value * int'(ch)) & 'h7FFF;
        value_sum  = (value_sum + value) & 'h1FFF;
      end
      if (int'(ch) == NCH - 1) begin
        last_pos     = frame_position();
        res.position = POS_W'(last_pos);
        res.mask     = mask_acc;
        expected_frames.push_back(res);
        mask_acc   = '0;
        weight_sum = 0;
        value_sum  = 0;
      end
    end
  endtask

  // input transfers feed the model
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      update_bar_model(in_req_type, in_channel, in_lit_sample, in_dark_sample);
  end

  // result transfers against the oldest expected frame
  always @(posedge clk) begin : check_frames
    frame_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected transfer: position %0d, on_line_mask %b",
               out_position, out_on_line_mask);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_position);
          mismatch_count++;
        end
        if (out_on_line_mask !== want.mask) begin
          $error("on_line_mask: expected %b, actual %b", want.mask, out_on_line_mask);
          mismatch_count++;
        end
      end
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic req, input logic [CH_W-1:0] ch,
                           input logic [SB-1:0] lit, input logic [SB-1:0] dark);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_req_type    <= req;
    in_channel     <= ch;
    in_lit_sample  <= lit;
    in_dark_sample <= dark;
    do @(posedge clk); while (in_full);
  endtask

  // picks lit and dark so that the corrected reading equals raw
  task automatic send_raw(input logic req, input int ch, input int raw);
    int dark_lo;
    int dark_hi;
    int dark;
    dark_lo = (raw < SAMPLE_TOP) ? SAMPLE_TOP - raw : 0;
    dark_hi = (raw > SAMPLE_TOP) ? RAW_TOP - raw : SAMPLE_TOP;
    dark = $urandom_range(dark_hi, dark_lo);
    send_item(req, CH_W'(ch), SB'(raw + dark - SAMPLE_TOP), SB'(dark));
  endtask

  task automatic send_line_frame();
    int centre;
    int half;
    int ch;
    int offset;
    int r;
    centre = $urandom_range(NCH - 1);
    half = ($urandom_range(99) < 10) ? -1 : $urandom_range(2);
    for (ch = 0; ch < NCH; ch++) begin
      offset = (ch > centre) ? ch - centre : centre - ch;
      if ($urandom_range(99) < 10) r = $urandom_range(RAW_TOP);
      else if ($urandom_range(99) < 5) r = $urandom_range(1) * RAW_TOP;
      else if (offset <= half) r = $urandom_range(RAW_TOP, 1300);
      else r = $urandom_range(800);
      send_raw(REQ_MEASURE, ch, r);
    end
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lsp_pkg::cfg_reg_t idx, input int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= lsp_pkg::CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lsp_pkg::REG_LINE_THR:   line_thr = data & 'h3FF;
      lsp_pkg::REG_INCL_THR:   incl_thr = data & 'h3FF;
      lsp_pkg::REG_WHITE_LINE: white_line = data[0];
      default: ;
    endcase
  endtask

  task automatic test_uncalibrated_frame();
    for (int ch = 0; ch < NCH; ch++)
      send_item(REQ_MEASURE, CH_W'(ch), ch[0] ? SB'(SAMPLE_TOP) : '0,
                ch[1] ? SB'(SAMPLE_TOP) : '0);
  endtask

  task automatic test_calibration_sweep();
    send_raw(REQ_CALIBRATE, 2, 0);
    send_raw(REQ_CALIBRATE, 2, RAW_TOP);
    send_raw(REQ_CALIBRATE, 3, 500);
    send_raw(REQ_CALIBRATE, 3, 1500);
    send_raw(REQ_CALIBRATE, 4, 500);
    send_raw(REQ_CALIBRATE, 4, 1500);
    send_raw(REQ_CALIBRATE, 5, 0);
    send_raw(REQ_CALIBRATE, 5, RAW_TOP);
  endtask

  // channels 3 and 4 clamp high and low, outer channels have no span
  task automatic test_interior_frame();
    int raws [8];
    raws = '{RAW_TOP, 0, SAMPLE_TOP, RAW_TOP, 0, 1500, 700, RAW_TOP};
    for (int ch = 0; ch < NCH; ch++) send_raw(REQ_MEASURE, ch, raws[ch]);
  endtask

  task automatic test_random_traffic(input int line, input int incl, input int white,
                                     input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int kind;
    int len;
    write_reg(lsp_pkg::REG_LINE_THR, line);
    write_reg(lsp_pkg::REG_INCL_THR, incl);
    write_reg(lsp_pkg::REG_WHITE_LINE, white);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        len = $urandom_range(12, 4);
        repeat (len) begin
          send_raw(REQ_CALIBRATE, $urandom_range(NCH - 1),
                   ($urandom_range(99) < 3) ? $urandom_range(1) * RAW_TOP
                                            : $urandom_range(1700, 300));
          sent++;
        end
      end else if (kind < 85) begin
        send_line_frame();
        sent += NCH;
      end else begin
        len = $urandom_range(10, 1);
        repeat (len) begin
          send_item(1'($urandom_range(1)), CH_W'($urandom_range(NCH - 1)),
                    SB'($urandom_range(SAMPLE_TOP)), SB'($urandom_range(SAMPLE_TOP)));
          sent++;
        end
      end
    end
    settle();
  endtask

  task automatic test_receiver_holdoff();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start  = 1'b1;
    repeat (6) send_line_frame();
    settle();
  endtask

  task automatic test_sender_drain_pause();
    tx_idle_pct = 20;
    rx_idle_pct = 40;
    send_line_frame();
    in_push <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    send_line_frame();
    send_line_frame();
    settle();
  endtask

  initial begin
    init_bar_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    rx_idle_pct = 30;
    test_uncalibrated_frame();
    test_calibration_sweep();
    test_interior_frame();
    settle();
    test_random_traffic(lsp_pkg::LINE_THR_RST, lsp_pkg::INCL_THR_RST, 0, 110, 6, 85);
    test_random_traffic(0, 1023, 0, 110, 6, 85);
    test_random_traffic(1023, 0, 1, 110, 85, 6);
    test_random_traffic(200, 700, 1, 110, 85, 6);
    test_random_traffic($urandom_range(1023), $urandom_range(1023), $urandom_range(1),
                        110, 0, 0);
    test_random_traffic(700, 300, 0, 110, 0, 0);
    test_receiver_holdoff();
    test_sender_drain_pause();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
